@@ rtl/core/lvm_pkg.sv @@
// Shared types and constants for the look-at view matrix block.
// Holds the item structs, the word and normalize widths and the default fraction width.
// No dependencies.
package lvm_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NORM_BITS     = 30;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] eye_x;
    logic signed [WORD_BITS-1:0] eye_y;
    logic signed [WORD_BITS-1:0] eye_z;
    logic signed [WORD_BITS-1:0] target_x;
    logic signed [WORD_BITS-1:0] target_y;
    logic signed [WORD_BITS-1:0] target_z;
    logic signed [WORD_BITS-1:0] up_x;
    logic signed [WORD_BITS-1:0] up_y;
    logic signed [WORD_BITS-1:0] up_z;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] elem_0;
    logic signed [WORD_BITS-1:0] elem_1;
    logic signed [WORD_BITS-1:0] elem_2;
    logic signed [WORD_BITS-1:0] elem_3;
    logic [1:0]                  row_num;
    logic                        last_row;
    logic                        degenerate;
  } out_item_t;

endpackage

@@ rtl/core/lvm_norm.sv @@
// Pipelined vector normalizer: abs, max, binary normalize shift, squares,
// digit-by-digit square root and restoring divide, one step per stage.
// Depends on lvm_pkg for NORM_BITS.
module lvm_norm #(
  parameter int VW        = 33,
  parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF,
  parameter int SBW       = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_v,
  input  logic [2:0][VW-1:0]         in_vec,
  input  logic [SBW-1:0]             in_sb,
  output logic                       out_v,
  output logic [2:0][FRAC_BITS+1:0]  out_unit,
  output logic                       out_zero,
  output logic [SBW-1:0]             out_sb
);
  import lvm_pkg::*;

  localparam int NB  = NORM_BITS;
  localparam int UW  = FRAC_BITS + 2;
  localparam int XW  = VW + NB;
  localparam int LS  = $clog2(XW);
  localparam int SQW = 2 * NB + 2;
  localparam int RT  = NB + 1;
  localparam int RW  = NB + 4;
  localparam int QB  = FRAC_BITS + 1;
  localparam int NW  = NB + FRAC_BITS + 2;
  localparam int DW  = NB + 2;
  localparam int NST = LS + RT + QB + 6;
  localparam int LW  = SBW + 3;

  // valid bits and sideband (with component signs) travel alongside
  logic [NST:1]   v_r;
  logic [LW-1:0]  line_r [1:NST];
  logic [2:0]     in_neg;

  assign in_neg = {in_vec[2][VW-1], in_vec[1][VW-1], in_vec[0][VW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-1:1], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      line_r[1] <= {in_sb, in_neg};
    end
  end

  for (genvar s = 2; s <= NST; s++) begin : g_line
    always_ff @(posedge clk) begin
      if (adv) begin
        line_r[s] <= line_r[s-1];
      end
    end
  end

  // magnitudes
  logic [2:0][VW-1:0] mag_r;
  for (genvar g = 0; g < 3; g++) begin : g_mag
    always_ff @(posedge clk) begin
      if (adv) begin
        mag_r[g] <= in_vec[g][VW-1] ? (~in_vec[g] + 1'b1) : in_vec[g];
      end
    end
  end

  // largest magnitude, widened for the normalize shift
  logic [VW-1:0]      m01, mmax;
  logic [2:0][XW-1:0] x_r  [0:LS];
  logic [XW-1:0]      xm_r [0:LS];

  assign m01  = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign mmax = (m01 > mag_r[2]) ? m01 : mag_r[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      xm_r[0] <= XW'(mmax);
      x_r[0]  <= {XW'(mag_r[2]), XW'(mag_r[1]), XW'(mag_r[0])};
    end
  end

  // shift left until the largest magnitude reaches the top bit
  for (genvar s = 1; s <= LS; s++) begin : g_shift
    localparam int SH = 2 ** (LS - s);
    logic sh_do;
    assign sh_do = (xm_r[s-1][XW-1 -: SH] == '0);
    always_ff @(posedge clk) begin
      if (adv) begin
        xm_r[s] <= sh_do ? (xm_r[s-1] << SH) : xm_r[s-1];
      end
    end
    for (genvar g = 0; g < 3; g++) begin : g_comp
      always_ff @(posedge clk) begin
        if (adv) begin
          x_r[s][g] <= sh_do ? (x_r[s-1][g] << SH) : x_r[s-1][g];
        end
      end
    end
  end

  // squares of the top bits
  logic [2:0][NB-1:0]   nm_r;
  logic [2:0][2*NB-1:0] sqc_r;
  for (genvar g = 0; g < 3; g++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        nm_r[g]  <= x_r[LS][g][XW-1 -: NB];
        sqc_r[g] <= x_r[LS][g][XW-1 -: NB] * x_r[LS][g][XW-1 -: NB];
      end
    end
  end

  // square root, one result bit per stage
  logic [SQW-1:0]     sq_r   [0:RT];
  logic [RW-1:0]      rem_r  [0:RT];
  logic [RT-1:0]      root_r [0:RT];
  logic [2:0][NB-1:0] snm_r  [0:RT];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0]   <= SQW'(sqc_r[0]) + SQW'(sqc_r[1]) + SQW'(sqc_r[2]);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      snm_r[0]  <= nm_r;
    end
  end

  for (genvar t = 1; t <= RT; t++) begin : g_sqrt
    localparam int J = RT - t;
    logic [RW-1:0] rb, tr;
    assign rb = {rem_r[t-1][RW-3:0], sq_r[t-1][2*J +: 2]};
    assign tr = {1'b0, root_r[t-1], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[t]  <= sq_r[t-1];
        snm_r[t] <= snm_r[t-1];
        if (rb >= tr) begin
          rem_r[t]  <= rb - tr;
          root_r[t] <= {root_r[t-1][RT-2:0], 1'b1};
        end else begin
          rem_r[t]  <= rb;
          root_r[t] <= {root_r[t-1][RT-2:0], 1'b0};
        end
      end
    end
  end

  // rounded divide: (mag * 2^(F+1) + len) / (2 * len)
  logic [2:0][NW-1:0] num_r [0:QB];
  logic [DW-1:0]      den_r [0:QB];
  logic [2:0][QB-1:0] quo_r [0:QB];

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0] <= {root_r[RT], 1'b0};
      quo_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_dset
    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[0][g] <= (NW'(snm_r[RT][g]) << (FRAC_BITS + 1)) + NW'(root_r[RT]);
      end
    end
  end

  for (genvar t = 1; t <= QB; t++) begin : g_div
    localparam int J = QB - t;
    logic [NW-1:0] dsh;
    assign dsh = NW'(den_r[t-1]) << J;
    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[t] <= den_r[t-1];
      end
    end
    for (genvar g = 0; g < 3; g++) begin : g_comp
      always_ff @(posedge clk) begin
        if (adv) begin
          if (num_r[t-1][g] >= dsh) begin
            num_r[t][g] <= num_r[t-1][g] - dsh;
            quo_r[t][g] <= {quo_r[t-1][g][QB-2:0], 1'b1};
          end else begin
            num_r[t][g] <= num_r[t-1][g];
            quo_r[t][g] <= {quo_r[t-1][g][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // reapply signs; a zero length forces zero components
  logic               zero;
  logic [2:0][UW-1:0] u_r;
  logic               z_r;

  assign zero = (den_r[QB] == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      z_r <= zero;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_fin
    logic [UW-1:0] qv;
    assign qv = {1'b0, quo_r[QB][g]};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (zero) begin
          u_r[g] <= '0;
        end else begin
          u_r[g] <= line_r[NST-1][g] ? (~qv + 1'b1) : qv;
        end
      end
    end
  end

  assign out_v    = v_r[NST];
  assign out_unit = u_r;
  assign out_zero = z_r;
  assign out_sb   = line_r[NST][LW-1:3];

endmodule

@@ rtl/core/lvm_cross.sv @@
// Two-stage cross product a x b: six products, then three differences.
// Carries a sideband word and a valid bit; depends on no package.
module lvm_cross #(
  parameter int AW  = 32,
  parameter int BW  = 18,
  parameter int SBW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_v,
  input  logic [2:0][AW-1:0]     in_a,
  input  logic [2:0][BW-1:0]     in_b,
  input  logic [SBW-1:0]         in_sb,
  output logic                   out_v,
  output logic [2:0][AW+BW:0]    out_c,
  output logic [SBW-1:0]         out_sb
);

  localparam int PW = AW + BW;

  logic [1:0]              v_r;
  logic [SBW-1:0]          sb1_r, sb2_r;
  logic signed [PW-1:0]    p_r [0:5];
  logic signed [PW:0]      c_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1_r  <= in_sb;
      sb2_r  <= sb1_r;
      p_r[0] <= $signed(in_a[1]) * $signed(in_b[2]);
      p_r[1] <= $signed(in_a[2]) * $signed(in_b[1]);
      p_r[2] <= $signed(in_a[2]) * $signed(in_b[0]);
      p_r[3] <= $signed(in_a[0]) * $signed(in_b[2]);
      p_r[4] <= $signed(in_a[0]) * $signed(in_b[1]);
      p_r[5] <= $signed(in_a[1]) * $signed(in_b[0]);
      c_r[0] <= p_r[0] - p_r[1];
      c_r[1] <= p_r[2] - p_r[3];
      c_r[2] <= p_r[4] - p_r[5];
    end
  end

  assign out_v    = v_r[1];
  assign out_sb   = sb2_r;
  assign out_c[0] = c_r[0];
  assign out_c[1] = c_r[1];
  assign out_c[2] = c_r[2];

endmodule

@@ rtl/core/lvm_rows.sv @@
// Translation column (three stages) and the four-row output serializer.
// Produces the pipeline advance enable; depends on lvm_pkg for item types.
module lvm_rows #(
  parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_v,
  input  logic [2:0][lvm_pkg::WORD_BITS-1:0]       in_eye,
  input  logic [2:0][FRAC_BITS+1:0]                in_rt,
  input  logic [2:0][FRAC_BITS+1:0]                in_uv,
  input  logic [2:0][FRAC_BITS+1:0]                in_lk,
  input  logic                                     in_degen,
  output logic                                     adv,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output lvm_pkg::out_item_t                       out_data
);
  import lvm_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int UW = FRAC_BITS + 2;
  localparam int PW = UW + W;
  localparam int TW = PW + 3;
  localparam logic signed [TW-1:0] HALF   = TW'(1) << (FRAC_BITS - 1);
  localparam logic signed [TW-1:0] SAT_HI = {{(TW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [TW-1:0] SAT_LO = {{(TW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0]         ONE_Q  = W'(1) << FRAC_BITS;

  logic [2:0][2:0][UW-1:0] uin;
  assign uin[0] = in_rt;
  assign uin[1] = in_uv;
  assign uin[2] = in_lk;

  logic                    v1_r, v2_r, v3_r;
  logic                    deg1_r, deg2_r, deg3_r;
  logic [2:0][2:0][W-1:0]  unit1_r, unit2_r, unit3_r;
  logic signed [PW-1:0]    p_r [0:2][0:2];
  logic signed [TW-1:0]    t2_r [0:2];
  logic [2:0][W-1:0]       tr3_r;

  logic                    busy_r, ser_free, load;
  logic [1:0]              row_r;
  logic [2:0][2:0][W-1:0]  h_unit_r;
  logic [2:0][W-1:0]       h_tr_r;
  logic                    h_deg_r;

  assign ser_free = !busy_r || (!out_stall && row_r == ROW_LAST);
  assign adv      = !v3_r || ser_free;
  assign load     = adv && v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg1_r  <= in_degen;
      deg2_r  <= deg1_r;
      deg3_r  <= deg2_r;
      unit2_r <= unit1_r;
      unit3_r <= unit2_r;
    end
  end

  for (genvar gv = 0; gv < 3; gv++) begin : g_vec
    logic signed [TW-1:0] q;
    assign q = t2_r[gv] >>> FRAC_BITS;
    for (genvar gc = 0; gc < 3; gc++) begin : g_comp
      always_ff @(posedge clk) begin
        if (adv) begin
          p_r[gv][gc]     <= $signed(uin[gv][gc]) * $signed(in_eye[gc]);
          unit1_r[gv][gc] <= W'($signed(uin[gv][gc]));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        t2_r[gv] <= HALF - (p_r[gv][0] + p_r[gv][1] + p_r[gv][2]);
        if (q > SAT_HI) begin
          tr3_r[gv] <= SAT_HI[W-1:0];
        end else if (q < SAT_LO) begin
          tr3_r[gv] <= SAT_LO[W-1:0];
        end else begin
          tr3_r[gv] <= q[W-1:0];
        end
      end
    end
  end

  // hold one matrix and step through its rows, one transfer per row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= ROW_FIRST;
    end else if (load) begin
      busy_r <= 1'b1;
      row_r  <= ROW_FIRST;
    end else if (busy_r && !out_stall) begin
      if (row_r == ROW_LAST) begin
        busy_r <= 1'b0;
      end else begin
        row_r <= row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h_unit_r <= unit3_r;
      h_tr_r   <= tr3_r;
      h_deg_r  <= deg3_r;
    end
  end

  always_comb begin
    out_data.row_num    = row_r;
    out_data.last_row   = (row_r == ROW_LAST);
    out_data.degenerate = h_deg_r;
    if (row_r == ROW_LAST) begin
      out_data.elem_0 = h_tr_r[0];
      out_data.elem_1 = h_tr_r[1];
      out_data.elem_2 = h_tr_r[2];
      out_data.elem_3 = ONE_Q;
    end else begin
      out_data.elem_0 = h_unit_r[0][row_r];
      out_data.elem_1 = h_unit_r[1][row_r];
      out_data.elem_2 = h_unit_r[2][row_r];
      out_data.elem_3 = '0;
    end
  end

  assign out_valid = busy_r;

endmodule

@@ rtl/core/lookat_view_matrix.sv @@
// Look-at view matrix: after an input transfer the first row appears, then
// one row per cycle while out_stall is low, for four rows.
// Throughput is one input per four-row matrix, set by the single row output port;
// the pipeline accepts a new item in any cycle its last stage can move.
// Reset clears only valid bits and the row serializer; data registers are not reset.
module lookat_view_matrix #(
  parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lvm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lvm_pkg::out_item_t  out_data
);
  import lvm_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int UW   = FRAC_BITS + 2;
  localparam int C1W  = W + UW + 1;
  localparam int C2W  = 2 * UW + 1;
  localparam int SB1W = 6 * W;
  localparam int SB2W = 3 * W + 3 * UW + 1;
  localparam int SB3W = 3 * W + 6 * UW + 1;

  logic adv;
  assign in_stall = !adv;

  // input stage: target - eye at full width
  logic                 v0_r;
  logic [2:0][W-1:0]    eye_r, up_r;
  logic [2:0][W:0]      d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eye_r <= {in_data.eye_z, in_data.eye_y, in_data.eye_x};
      up_r  <= {in_data.up_z, in_data.up_y, in_data.up_x};
      d_r[0] <= {in_data.target_x[W-1], in_data.target_x}
              - {in_data.eye_x[W-1], in_data.eye_x};
      d_r[1] <= {in_data.target_y[W-1], in_data.target_y}
              - {in_data.eye_y[W-1], in_data.eye_y};
      d_r[2] <= {in_data.target_z[W-1], in_data.target_z}
              - {in_data.eye_z[W-1], in_data.eye_z};
    end
  end

  // look
  logic                 n1_v, n1_z;
  logic [2:0][UW-1:0]   n1_lk;
  logic [SB1W-1:0]      n1_sb;
  logic [2:0][W-1:0]    eye_a, up_a;

  lvm_norm #(.VW(W + 1), .FRAC_BITS(FRAC_BITS), .SBW(SB1W)) u_norm_look (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(v0_r), .in_vec(d_r),
    .in_sb({eye_r, up_r}), .out_v(n1_v), .out_unit(n1_lk), .out_zero(n1_z),
    .out_sb(n1_sb)
  );
  assign {eye_a, up_a} = n1_sb;

  // right = normalize(up x look)
  logic                 x1_v;
  logic [2:0][C1W-1:0]  x1_c;
  logic [SB2W-1:0]      x1_sb;

  lvm_cross #(.AW(W), .BW(UW), .SBW(SB2W)) u_cross_right (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(n1_v), .in_a(up_a),
    .in_b(n1_lk), .in_sb({eye_a, n1_lk, n1_z}), .out_v(x1_v), .out_c(x1_c),
    .out_sb(x1_sb)
  );

  logic                 n2_v, n2_z;
  logic [2:0][UW-1:0]   n2_rt;
  logic [SB2W-1:0]      n2_sb;
  logic [2:0][W-1:0]    eye_b;
  logic [2:0][UW-1:0]   lk_b;
  logic                 z_b;

  lvm_norm #(.VW(C1W), .FRAC_BITS(FRAC_BITS), .SBW(SB2W)) u_norm_right (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(x1_v), .in_vec(x1_c),
    .in_sb(x1_sb), .out_v(n2_v), .out_unit(n2_rt), .out_zero(n2_z),
    .out_sb(n2_sb)
  );
  assign {eye_b, lk_b, z_b} = n2_sb;

  // upv = normalize(look x right)
  logic                 x2_v;
  logic [2:0][C2W-1:0]  x2_c;
  logic [SB3W-1:0]      x2_sb;

  lvm_cross #(.AW(UW), .BW(UW), .SBW(SB3W)) u_cross_up (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(n2_v), .in_a(lk_b),
    .in_b(n2_rt), .in_sb({eye_b, lk_b, n2_rt, z_b | n2_z}), .out_v(x2_v),
    .out_c(x2_c), .out_sb(x2_sb)
  );

  logic                 n3_v, n3_z;
  logic [2:0][UW-1:0]   n3_uv;
  logic [SB3W-1:0]      n3_sb;
  logic [2:0][W-1:0]    eye_c;
  logic [2:0][UW-1:0]   lk_c, rt_c;
  logic                 z_c;

  lvm_norm #(.VW(C2W), .FRAC_BITS(FRAC_BITS), .SBW(SB3W)) u_norm_up (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(x2_v), .in_vec(x2_c),
    .in_sb(x2_sb), .out_v(n3_v), .out_unit(n3_uv), .out_zero(n3_z),
    .out_sb(n3_sb)
  );
  assign {eye_c, lk_c, rt_c, z_c} = n3_sb;

  lvm_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
    .clk(clk), .rst_n(rst_n), .in_v(n3_v), .in_eye(eye_c), .in_rt(rt_c),
    .in_uv(n3_uv), .in_lk(lk_c), .in_degen(z_c | n3_z), .adv(adv),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

@@ verif/lookat_view_matrix_tb.sv @@
// Testbench for lookat_view_matrix: random and directed camera setups checked
// row by row against a fixed-point look-at predictor. Needs lvm_pkg only.
module lookat_view_matrix_tb;
  import lvm_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int NORM = NORM_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 240;
  localparam logic signed [31:0] MAXW = 32'sh7fffffff;
  localparam logic signed [31:0] MINW = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  class view_matrix_board;
    out_item_t rows_due[$];
    int errors;

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Scale so the largest magnitude has NORM bits, then divide by the length.
    function bit unit_vec(input longint v[3], output longint o[3]);
      longint unsigned mag[3], m, sq, len, q;
      int bl;
      m = 0;
      sq = 0;
      bl = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        o[0] = 0; o[1] = 0; o[2] = 0;
        return 0;
      end
      while (bl < 64 && (m >> bl) != 0) bl++;
      for (int i = 0; i < 3; i++) begin
        if (bl > NORM) mag[i] >>= (bl - NORM);
        else mag[i] <<= (NORM - bl);
        sq += mag[i] * mag[i];
      end
      len = isqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << (FRAC + 1)) + len) / (len * 2);
        o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function void cross3(input longint a[3], input longint b[3], output longint o[3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Negated dot product, rounded half up, saturated to the word.
    function logic signed [31:0] shift_term(input longint u[3], input longint e[3]);
      longint t;
      t = -(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]);
      t += longint'(1) << (FRAC - 1);
      t = t >>> FRAC;
      if (t > longint'(MAXW)) return MAXW;
      if (t < longint'(MINW)) return MINW;
      return t[31:0];
    endfunction

    function void note_input(in_item_t it);
      longint eye[3], d[3], up[3], c[3], lk[3], rt[3], uv[3];
      logic signed [31:0] m[4][4];
      bit degen;
      out_item_t r;
      eye = '{it.eye_x, it.eye_y, it.eye_z};
      up = '{it.up_x, it.up_y, it.up_z};
      d[0] = longint'(it.target_x) - eye[0];
      d[1] = longint'(it.target_y) - eye[1];
      d[2] = longint'(it.target_z) - eye[2];
      degen = 0;
      if (!unit_vec(d, lk)) degen = 1;
      cross3(up, lk, c);
      if (!unit_vec(c, rt)) degen = 1;
      cross3(lk, rt, c);
      if (!unit_vec(c, uv)) degen = 1;
      for (int i = 0; i < 3; i++) begin
        m[i][0] = 32'(rt[i]);
        m[i][1] = 32'(uv[i]);
        m[i][2] = 32'(lk[i]);
        m[i][3] = 0;
      end
      m[3][0] = shift_term(rt, eye);
      m[3][1] = shift_term(uv, eye);
      m[3][2] = shift_term(lk, eye);
      m[3][3] = ONE;
      for (int k = 0; k < 4; k++) begin
        r.elem_0 = m[k][0];
        r.elem_1 = m[k][1];
        r.elem_2 = m[k][2];
        r.elem_3 = m[k][3];
        r.row_num = k[1:0];
        r.last_row = (k[1:0] == ROW_LAST);
        r.degenerate = degen;
        rows_due.push_back(r);
      end
    endfunction

    task report(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", field, got, want);
      errors++;
    endtask

    task check_row(out_item_t got);
      out_item_t w;
      if (rows_due.size() == 0) begin
        report("unexpected row", got.row_num, -1);
        return;
      end
      w = rows_due.pop_front();
      if (got.elem_0 !== w.elem_0) report("elem_0", got.elem_0, w.elem_0);
      if (got.elem_1 !== w.elem_1) report("elem_1", got.elem_1, w.elem_1);
      if (got.elem_2 !== w.elem_2) report("elem_2", got.elem_2, w.elem_2);
      if (got.elem_3 !== w.elem_3) report("elem_3", got.elem_3, w.elem_3);
      if (got.row_num !== w.row_num) report("row_num", got.row_num, w.row_num);
      if (got.last_row !== w.last_row) report("last_row", got.last_row, w.last_row);
      if (got.degenerate !== w.degenerate)
        report("degenerate", got.degenerate, w.degenerate);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  bit quiet;
  int cycles;
  int stall_left;
  int stall_hold;
  view_matrix_board board;

  lookat_view_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_input(in_data);
    if (rst_n && out_valid && !out_stall) board.check_row(out_data);
  end

  // Result side: stall in bursts, with idle stretches between them.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_stall <= 0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1;
    end else begin
      stall_hold <= $urandom_range(0, 1) ? $urandom_range(5, 40) : 0;
      out_stall <= 0;
    end
  end

  task send(in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task send_vecs(logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    in_item_t it;
    it = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    send(it);
  endtask

  function logic signed [31:0] pick_word(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      2: return $urandom_range(0, 1) ? MAXW : MINW;
      default: return $signed($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  initial begin
    in_item_t it;
    int mode;
    board = new();
    cycles = 0;
    quiet = 0;
    stall_left = 0;
    stall_hold = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // all zero: every vector degenerate
    send_vecs(0, 0, 0, 0, 0, 0, 0, 0, 0);
    // eye on target
    send_vecs(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0);
    // up parallel to look: right collapses
    send_vecs(0, 0, 0, 0, 5 * ONE, 0, 0, ONE, 0);
    // textbook camera
    send_vecs(0, 0, -5 * ONE, 0, 0, 0, 0, ONE, 0);
    send_vecs(3 * ONE, 4 * ONE, 5 * ONE, 0, 0, 0, 0, ONE, 0);
    // field extremes and a saturating translation
    send_vecs(MAXW, MAXW, MAXW, MINW, MINW, MINW, 0, ONE, 0);
    send_vecs(MINW, MINW, MINW, MAXW, MAXW, MAXW, MAXW, MINW, MAXW);
    send_vecs(MAXW, MINW, MAXW, MINW, MAXW, MINW, MINW, MINW, MINW);
    send_vecs(MAXW, MAXW, MAXW, 0, 0, 0, 1, 0, 0);
    send_vecs(MINW, MINW, MINW, 0, 0, 0, 0, 0, -1);
    send_vecs(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_vecs(-1, -1, -1, 0, 0, 0, MAXW, 0, MINW);
    send_vecs(32'sh7fff, -32'sh1234, 32'sh55aa55, -ONE, ONE, ONE, 1, 1, 1);

    for (int n = 0; n < 160; n++) begin
      if (n >= 130) quiet = 1;
      mode = $urandom_range(0, 9);
      it.eye_x = pick_word(mode % 4);
      it.eye_y = pick_word(mode % 4);
      it.eye_z = pick_word(mode % 4);
      it.target_x = pick_word((mode + 1) % 4);
      it.target_y = pick_word((mode + 1) % 4);
      it.target_z = pick_word((mode + 1) % 4);
      it.up_x = pick_word(mode % 3);
      it.up_y = pick_word(mode % 3);
      it.up_z = pick_word(mode % 3);
      if (mode == 9) it.target_x = it.eye_x;
      send(it);
    end
    in_valid <= 0;

    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
